// File: hdl/hk3_pkg.sv
// Shared types and constant tables for the 3-D Hilbert key pipeline.
// No dependencies; used by hk3_level and hilbert_key_3d_unit.
package hk3_pkg;

  localparam int COORD_W    = 20;
  localparam int KEY_W      = 60;
  localparam int NUM_STATES = 48;
  localparam int ORIENT_W   = 6;

  // Payload carried from one level stage to the next.
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [ORIENT_W-1:0] orient;
    logic [KEY_W-1:0]    key;
  } hk3_stage_t;

  localparam logic [ORIENT_W-1:0] STATE_AFTER [NUM_STATES][8] = '{
    '{6'd36, 6'd28, 6'd25, 6'd27, 6'd10, 6'd10, 6'd25, 6'd27},
    '{6'd29, 6'd11, 6'd24, 6'd24, 6'd37, 6'd11, 6'd26, 6'd26},
    '{6'd8,  6'd8,  6'd25, 6'd27, 6'd30, 6'd38, 6'd25, 6'd27},
    '{6'd9,  6'd39, 6'd24, 6'd24, 6'd9,  6'd31, 6'd26, 6'd26},
    '{6'd40, 6'd24, 6'd44, 6'd32, 6'd40, 6'd6,  6'd44, 6'd6},
    '{6'd25, 6'd7,  6'd33, 6'd7,  6'd41, 6'd41, 6'd45, 6'd45},
    '{6'd4,  6'd42, 6'd4,  6'd46, 6'd26, 6'd42, 6'd34, 6'd46},
    '{6'd43, 6'd43, 6'd47, 6'd47, 6'd5,  6'd27, 6'd5,  6'd35},
    '{6'd33, 6'd35, 6'd36, 6'd28, 6'd33, 6'd35, 6'd2,  6'd2},
    '{6'd32, 6'd32, 6'd29, 6'd3,  6'd34, 6'd34, 6'd37, 6'd3},
    '{6'd33, 6'd35, 6'd0,  6'd0,  6'd33, 6'd35, 6'd30, 6'd38},
    '{6'd32, 6'd32, 6'd1,  6'd39, 6'd34, 6'd34, 6'd1,  6'd31},
    '{6'd24, 6'd42, 6'd32, 6'd46, 6'd14, 6'd42, 6'd14, 6'd46},
    '{6'd43, 6'd43, 6'd47, 6'd47, 6'd25, 6'd15, 6'd33, 6'd15},
    '{6'd40, 6'd12, 6'd44, 6'd12, 6'd40, 6'd26, 6'd44, 6'd34},
    '{6'd13, 6'd27, 6'd13, 6'd35, 6'd41, 6'd41, 6'd45, 6'd45},
    '{6'd28, 6'd41, 6'd28, 6'd22, 6'd38, 6'd43, 6'd38, 6'd22},
    '{6'd42, 6'd40, 6'd23, 6'd23, 6'd29, 6'd39, 6'd29, 6'd39},
    '{6'd41, 6'd36, 6'd20, 6'd36, 6'd43, 6'd30, 6'd20, 6'd30},
    '{6'd37, 6'd31, 6'd37, 6'd31, 6'd42, 6'd40, 6'd21, 6'd21},
    '{6'd28, 6'd18, 6'd28, 6'd45, 6'd38, 6'd18, 6'd38, 6'd47},
    '{6'd19, 6'd19, 6'd46, 6'd44, 6'd29, 6'd39, 6'd29, 6'd39},
    '{6'd16, 6'd36, 6'd45, 6'd36, 6'd16, 6'd30, 6'd47, 6'd30},
    '{6'd37, 6'd31, 6'd37, 6'd31, 6'd17, 6'd17, 6'd46, 6'd44},
    '{6'd12, 6'd4,  6'd1,  6'd3,  6'd34, 6'd34, 6'd1,  6'd3},
    '{6'd5,  6'd35, 6'd0,  6'd0,  6'd13, 6'd35, 6'd2,  6'd2},
    '{6'd32, 6'd32, 6'd1,  6'd3,  6'd6,  6'd14, 6'd1,  6'd3},
    '{6'd33, 6'd15, 6'd0,  6'd0,  6'd33, 6'd7,  6'd2,  6'd2},
    '{6'd16, 6'd0,  6'd20, 6'd8,  6'd16, 6'd30, 6'd20, 6'd30},
    '{6'd1,  6'd31, 6'd9,  6'd31, 6'd17, 6'd17, 6'd21, 6'd21},
    '{6'd28, 6'd18, 6'd28, 6'd22, 6'd2,  6'd18, 6'd10, 6'd22},
    '{6'd19, 6'd19, 6'd23, 6'd23, 6'd29, 6'd3,  6'd29, 6'd11},
    '{6'd9,  6'd11, 6'd12, 6'd4,  6'd9,  6'd11, 6'd26, 6'd26},
    '{6'd8,  6'd8,  6'd5,  6'd27, 6'd10, 6'd10, 6'd13, 6'd27},
    '{6'd9,  6'd11, 6'd24, 6'd24, 6'd9,  6'd11, 6'd6,  6'd14},
    '{6'd8,  6'd8,  6'd25, 6'd15, 6'd10, 6'd10, 6'd25, 6'd7},
    '{6'd0,  6'd18, 6'd8,  6'd22, 6'd38, 6'd18, 6'd38, 6'd22},
    '{6'd19, 6'd19, 6'd23, 6'd23, 6'd1,  6'd39, 6'd9,  6'd39},
    '{6'd16, 6'd36, 6'd20, 6'd36, 6'd16, 6'd2,  6'd20, 6'd10},
    '{6'd37, 6'd3,  6'd37, 6'd11, 6'd17, 6'd17, 6'd21, 6'd21},
    '{6'd4,  6'd17, 6'd4,  6'd46, 6'd14, 6'd19, 6'd14, 6'd46},
    '{6'd18, 6'd16, 6'd47, 6'd47, 6'd5,  6'd15, 6'd5,  6'd15},
    '{6'd17, 6'd12, 6'd44, 6'd12, 6'd19, 6'd6,  6'd44, 6'd6},
    '{6'd13, 6'd7,  6'd13, 6'd7,  6'd18, 6'd16, 6'd45, 6'd45},
    '{6'd4,  6'd42, 6'd4,  6'd21, 6'd14, 6'd42, 6'd14, 6'd23},
    '{6'd43, 6'd43, 6'd22, 6'd20, 6'd5,  6'd15, 6'd5,  6'd15},
    '{6'd40, 6'd12, 6'd21, 6'd12, 6'd40, 6'd6,  6'd23, 6'd6},
    '{6'd13, 6'd7,  6'd13, 6'd7,  6'd41, 6'd41, 6'd22, 6'd20}
  };

  localparam logic [2:0] DIGIT_OF [NUM_STATES][8] = '{
    '{3'd0, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5},
    '{3'd7, 3'd4, 3'd6, 3'd5, 3'd0, 3'd3, 3'd1, 3'd2},
    '{3'd4, 3'd3, 3'd5, 3'd2, 3'd7, 3'd0, 3'd6, 3'd1},
    '{3'd3, 3'd0, 3'd2, 3'd1, 3'd4, 3'd7, 3'd5, 3'd6},
    '{3'd1, 3'd0, 3'd6, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4},
    '{3'd0, 3'd3, 3'd7, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5},
    '{3'd3, 3'd2, 3'd4, 3'd5, 3'd0, 3'd1, 3'd7, 3'd6},
    '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
    '{3'd6, 3'd1, 3'd7, 3'd0, 3'd5, 3'd2, 3'd4, 3'd3},
    '{3'd1, 3'd2, 3'd0, 3'd3, 3'd6, 3'd5, 3'd7, 3'd4},
    '{3'd2, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd0, 3'd7},
    '{3'd5, 3'd6, 3'd4, 3'd7, 3'd2, 3'd1, 3'd3, 3'd0},
    '{3'd7, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2},
    '{3'd6, 3'd5, 3'd1, 3'd2, 3'd7, 3'd4, 3'd0, 3'd3},
    '{3'd5, 3'd4, 3'd2, 3'd3, 3'd6, 3'd7, 3'd1, 3'd0},
    '{3'd4, 3'd7, 3'd3, 3'd0, 3'd5, 3'd6, 3'd2, 3'd1},
    '{3'd6, 3'd7, 3'd5, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3},
    '{3'd7, 3'd0, 3'd4, 3'd3, 3'd6, 3'd1, 3'd5, 3'd2},
    '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
    '{3'd1, 3'd6, 3'd2, 3'd5, 3'd0, 3'd7, 3'd3, 3'd4},
    '{3'd2, 3'd3, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7},
    '{3'd3, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd6},
    '{3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1},
    '{3'd5, 3'd2, 3'd6, 3'd1, 3'd4, 3'd3, 3'd7, 3'd0},
    '{3'd7, 3'd0, 3'd6, 3'd1, 3'd4, 3'd3, 3'd5, 3'd2},
    '{3'd0, 3'd3, 3'd1, 3'd2, 3'd7, 3'd4, 3'd6, 3'd5},
    '{3'd3, 3'd4, 3'd2, 3'd5, 3'd0, 3'd7, 3'd1, 3'd6},
    '{3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd0, 3'd2, 3'd1},
    '{3'd6, 3'd7, 3'd1, 3'd0, 3'd5, 3'd4, 3'd2, 3'd3},
    '{3'd7, 3'd4, 3'd0, 3'd3, 3'd6, 3'd5, 3'd1, 3'd2},
    '{3'd4, 3'd5, 3'd3, 3'd2, 3'd7, 3'd6, 3'd0, 3'd1},
    '{3'd5, 3'd6, 3'd2, 3'd1, 3'd4, 3'd7, 3'd3, 3'd0},
    '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd4},
    '{3'd6, 3'd5, 3'd7, 3'd4, 3'd1, 3'd2, 3'd0, 3'd3},
    '{3'd5, 3'd2, 3'd4, 3'd3, 3'd6, 3'd1, 3'd7, 3'd0},
    '{3'd2, 3'd1, 3'd3, 3'd0, 3'd5, 3'd6, 3'd4, 3'd7},
    '{3'd0, 3'd1, 3'd7, 3'd6, 3'd3, 3'd2, 3'd4, 3'd5},
    '{3'd1, 3'd2, 3'd6, 3'd5, 3'd0, 3'd3, 3'd7, 3'd4},
    '{3'd2, 3'd3, 3'd5, 3'd4, 3'd1, 3'd0, 3'd6, 3'd7},
    '{3'd3, 3'd0, 3'd4, 3'd7, 3'd2, 3'd1, 3'd5, 3'd6},
    '{3'd1, 3'd0, 3'd2, 3'd3, 3'd6, 3'd7, 3'd5, 3'd4},
    '{3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5},
    '{3'd7, 3'd6, 3'd4, 3'd5, 3'd0, 3'd1, 3'd3, 3'd2},
    '{3'd6, 3'd1, 3'd5, 3'd2, 3'd7, 3'd0, 3'd4, 3'd3},
    '{3'd5, 3'd4, 3'd6, 3'd7, 3'd2, 3'd3, 3'd1, 3'd0},
    '{3'd4, 3'd3, 3'd7, 3'd0, 3'd5, 3'd2, 3'd6, 3'd1},
    '{3'd3, 3'd2, 3'd0, 3'd1, 3'd4, 3'd5, 3'd7, 3'd6},
    '{3'd2, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd0, 3'd7}
  };

  // An orientation outside the table is treated as orientation zero.
  function automatic logic [ORIENT_W-1:0] next_orient(logic [ORIENT_W-1:0] orient,
                                                      logic [2:0] oct);
    if (orient < ORIENT_W'(NUM_STATES)) begin
      return STATE_AFTER[orient][oct];
    end else begin
      return STATE_AFTER[0][oct];
    end
  endfunction

  function automatic logic [2:0] digit(logic [ORIENT_W-1:0] orient, logic [2:0] oct);
    if (orient < ORIENT_W'(NUM_STATES)) begin
      return DIGIT_OF[orient][oct];
    end else begin
      return DIGIT_OF[0][oct];
    end
  endfunction

endpackage

// File: hdl/hilbert_key_3d_unit.sv
// Top level of the 3-D Hilbert key pipeline.
// Depends on hk3_pkg and hk3_level.

// Takes one coordinate triplet per cycle while in_stall is low and returns its
// 60-bit Hilbert key through a chain of LEVEL_BITS stage registers, one table
// step per level; the throughput is one item per cycle unless out_stall holds
// the chain. The whole chain holds while a finished key waits on out_stall, so
// in_stall follows out_valid and out_stall directly; there is no clearing
// pass and no configuration.
module hilbert_key_3d_unit #(
  parameter int LEVEL_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] coord_x,
  input  logic [19:0] coord_y,
  input  logic [19:0] coord_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [59:0] curve_key
);

  hk3_pkg::hk3_stage_t stage [LEVEL_BITS+1];
  logic [LEVEL_BITS:0] stage_valid;
  logic                en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign stage[0].x      = coord_x;
  assign stage[0].y      = coord_y;
  assign stage[0].z      = coord_z;
  assign stage[0].orient = '0;
  assign stage[0].key    = '0;
  assign stage_valid[0]  = in_valid;

  // Stage i handles the coordinate bit LEVEL_BITS-1-i, top bit first.
  generate
    for (genvar i = 0; i < LEVEL_BITS; i++) begin : g_level
      hk3_level #(
        .LEVEL (LEVEL_BITS - 1 - i)
      ) u_level (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .up_valid (stage_valid[i]),
        .up       (stage[i]),
        .dn_valid (stage_valid[i+1]),
        .dn       (stage[i+1])
      );
    end
  endgenerate

  assign out_valid = stage_valid[LEVEL_BITS];
  assign curve_key = stage[LEVEL_BITS].key;

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(stage_valid[LEVEL_BITS:1]))
    else $error("pipeline moved while stalled");

  a_zero_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && (stage[LEVEL_BITS].x == '0) && (stage[LEVEL_BITS].y == '0) &&
    (stage[LEVEL_BITS].z == '0) |-> curve_key == '0)
    else $error("origin did not map to key zero");

  a_accept_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> stage_valid[1])
    else $error("accepted item not captured");

endmodule

// File: hdl/hk3_level.sv
// One level of the Hilbert key pipeline: table step plus its stage register.
// Depends on hk3_pkg.
module hk3_level #(
  parameter int LEVEL = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              up_valid,
  input  hk3_pkg::hk3_stage_t up,
  output logic              dn_valid,
  output hk3_pkg::hk3_stage_t dn
);

  logic [2:0]          oct;
  hk3_pkg::hk3_stage_t dn_next;

  // A level at or above the coordinate width reads its coordinate bits as zero.
  generate
    if (LEVEL < hk3_pkg::COORD_W) begin : g_bit
      assign oct = {up.x[LEVEL], up.y[LEVEL], up.z[LEVEL]};
    end else begin : g_zero
      assign oct = 3'd0;
    end
  endgenerate

  always_comb begin
    dn_next        = up;
    dn_next.orient = hk3_pkg::next_orient(up.orient, oct);
    dn_next.key    = {up.key[hk3_pkg::KEY_W-4:0], hk3_pkg::digit(up.orient, oct)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn <= dn_next;
    end
  end

  a_orient_range: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> (dn.orient < hk3_pkg::ORIENT_W'(hk3_pkg::NUM_STATES)))
    else $error("stage orientation outside table");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dn_valid) && (!dn_valid || $stable(dn)))
    else $error("stage changed while held");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en |=> dn_valid == $past(up_valid))
    else $error("stage valid did not follow upstream");

endmodule
